### sv/lhud_pkg.sv
// Shared types and constants for the length-header unescape decoder.
// Holds the phase, command and result codes and the packed records
// passed between the front end, the command queue and the back end.
`timescale 1ns / 1ps
`default_nettype none

package lhud_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 32;
  localparam int LEN_MAX_WIDTH        = 64;
  localparam int QUEUE_DEPTH_DEFAULT  = 2;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ESCAPE = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_DIGIT    = 3'd0,
    OP_COLON    = 3'd1,
    OP_DATA     = 3'd2,
    OP_ESC_LAST = 3'd3,
    OP_BAD_ESC  = 3'd4,
    OP_SKIP     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_LENGTH     = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_BAD_ESCAPE = 2'd3
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] declared_length;
    logic [31:0] byte_index;
    logic        beyond_length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### sv/lhud_fifo.sv
// Small register-based FIFO used for the command queue and the result queue.
// Depends on nothing but its WIDTH and DEPTH parameters.
`timescale 1ns / 1ps
`default_nettype none

module lhud_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/lhud_front.sv
// Front end: tracks the message phase and turns each character into a command.
// Depends on lhud_pkg for phase and command types.
`timescale 1ns / 1ps
`default_nettype none

module lhud_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output lhud_pkg::cmd_t     cmd
);

  lhud_pkg::phase_t phase;
  lhud_pkg::phase_t phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lhud_pkg::PH_HEADER;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    cmd.op     = lhud_pkg::OP_SKIP;
    cmd.data   = in_byte;
    cmd.last   = in_last;
    case (phase)
      lhud_pkg::PH_HEADER: begin
        if (in_byte == lhud_pkg::CH_COLON) begin
          cmd.op     = lhud_pkg::OP_COLON;
          phase_next = lhud_pkg::PH_BODY;
        end else begin
          cmd.op = lhud_pkg::OP_DIGIT;
        end
      end
      lhud_pkg::PH_BODY: begin
        if (in_byte == lhud_pkg::CH_PIPE) begin
          if (in_last) begin
            cmd.op = lhud_pkg::OP_ESC_LAST;
          end else begin
            phase_next = lhud_pkg::PH_ESCAPE;
          end
        end else begin
          cmd.op = lhud_pkg::OP_DATA;
        end
      end
      lhud_pkg::PH_ESCAPE: begin
        cmd.op     = lhud_pkg::OP_DATA;
        phase_next = lhud_pkg::PH_BODY;
        case (in_byte)
          lhud_pkg::CH_Z: cmd.data = lhud_pkg::BYTE_NUL;
          lhud_pkg::CH_L: cmd.data = lhud_pkg::BYTE_LF;
          lhud_pkg::CH_F: cmd.data = lhud_pkg::BYTE_CR;
          lhud_pkg::CH_P: cmd.data = lhud_pkg::CH_PIPE;
          default: begin
            cmd.op     = lhud_pkg::OP_BAD_ESC;
            phase_next = lhud_pkg::PH_DROP;
          end
        endcase
      end
      default: begin
        cmd.op = lhud_pkg::OP_SKIP;
      end
    endcase
    // The end of a message always returns the decoder to the header phase.
    if (in_last) begin
      phase_next = lhud_pkg::PH_HEADER;
    end
  end

endmodule

`default_nettype wire

### sv/lhud_back.sv
// Back end: executes commands, keeping the length accumulator and data index.
// Depends on lhud_pkg for command and result types.
`timescale 1ns / 1ps
`default_nettype none

module lhud_back #(
  parameter int LENGTH_WIDTH = lhud_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire lhud_pkg::cmd_t cmd,
  output logic                res_valid,
  output lhud_pkg::result_t   res
);

  localparam int MW = lhud_pkg::LEN_MAX_WIDTH;

  logic [LENGTH_WIDTH-1:0] acc;
  logic [LENGTH_WIDTH-1:0] acc_next;
  logic [LENGTH_WIDTH-1:0] acc_upd;
  logic [31:0]             idx;
  logic [31:0]             idx_next;
  logic [MW-1:0]           acc_ext;
  logic [MW-1:0]           acc_upd_ext;
  logic                    beyond;

  // acc * 10 as two shifted copies, then add the character minus '0'.
  assign acc_upd = (acc << 3) + (acc << 1) + LENGTH_WIDTH'(cmd.data)
                   - LENGTH_WIDTH'(lhud_pkg::CH_ZERO);
  assign acc_ext     = MW'(acc);
  assign acc_upd_ext = MW'(acc_upd);
  assign beyond      = (MW'(idx) >= acc_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      idx <= '0;
    end else if (take) begin
      acc <= acc_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    acc_next            = acc;
    idx_next            = idx;
    res_valid           = 1'b0;
    res.kind            = lhud_pkg::KIND_DATA;
    res.data_byte       = '0;
    res.declared_length = acc_ext[31:0];
    res.byte_index      = idx;
    res.beyond_length   = 1'b0;
    res.last            = cmd.last;
    case (cmd.op)
      lhud_pkg::OP_DIGIT: begin
        acc_next            = acc_upd;
        res.declared_length = acc_upd_ext[31:0];
        res.kind            = lhud_pkg::KIND_BAD_HEADER;
        res_valid           = cmd.last;
      end
      lhud_pkg::OP_COLON: begin
        res.kind  = lhud_pkg::KIND_LENGTH;
        res_valid = 1'b1;
      end
      lhud_pkg::OP_DATA: begin
        res.kind          = lhud_pkg::KIND_DATA;
        res.data_byte     = cmd.data;
        res.beyond_length = beyond;
        res_valid         = 1'b1;
        idx_next          = idx + 32'd1;
      end
      lhud_pkg::OP_ESC_LAST, lhud_pkg::OP_BAD_ESC: begin
        res.kind  = lhud_pkg::KIND_BAD_ESCAPE;
        res.last  = 1'b1;
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (cmd.last) begin
      acc_next = '0;
      idx_next = '0;
    end
  end

endmodule

`default_nettype wire

### sv/length_header_unescape_decoder_unit.sv
// Top level of the length-header unescape decoder.
// Depends on lhud_pkg, lhud_fifo, lhud_front and lhud_back.
//
// Usage: messages of the form "<decimal length>:<escaped body>" arrive one
// character per request on the input queue port (push / full, in_byte,
// in_last). A request is taken at a clock edge with push high and full low.
// Results leave through the output queue port (empty / pop and the result
// fields); the oldest result is shown while empty is low and is taken at an
// edge with pop high. Each character gives zero or one result.
// The edge that takes a character writes its command into the command
// queue; the back end then writes the result queue when it has room, and
// the result is shown once it stands in the result queue.
// Throughput: one character per cycle while full stays low, set by the phase
// update in the front end and the accumulate in the back end.
// When the consumer stalls, the result queue fills, the back end stops
// draining commands, and full rises once the command queue is full too; no
// request is lost. A synchronous reset empties both queues and returns the
// decoder to the header phase with a zero length and index.
`timescale 1ns / 1ps
`default_nettype none

module length_header_unescape_decoder_unit #(
  parameter int LENGTH_WIDTH = lhud_pkg::LENGTH_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH  = lhud_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [31:0]      declared_length,
  output logic [31:0]      byte_index,
  output logic             beyond_length,
  output logic             out_last
);

  localparam int CMD_W = $bits(lhud_pkg::cmd_t);
  localparam int RES_W = $bits(lhud_pkg::result_t);

  logic              in_take;
  lhud_pkg::cmd_t    front_cmd;
  logic [CMD_W-1:0]  cmd_q_data;
  lhud_pkg::cmd_t    back_cmd;
  logic              cmd_empty;
  logic              back_take;
  logic              res_valid;
  lhud_pkg::result_t back_res;
  logic              res_full;
  logic [RES_W-1:0]  res_q_data;
  lhud_pkg::result_t out_res;

  // The front end classifies every accepted character in the same cycle and
  // writes one command, so the input side stalls only on the command queue.
  assign in_take = push && !full;

  lhud_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (in_take),
    .in_byte (in_byte),
    .in_last (in_last),
    .cmd     (front_cmd)
  );

  lhud_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_data (front_cmd),
    .rd_en   (back_take),
    .rd_data (cmd_q_data),
    .full    (full),
    .empty   (cmd_empty)
  );

  assign back_cmd = lhud_pkg::cmd_t'(cmd_q_data);

  // A command runs only when the result queue has room, whether or not it
  // produces a result, which keeps the accumulator update and the write tied.
  assign back_take = !cmd_empty && !res_full;

  lhud_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .take      (back_take),
    .cmd       (back_cmd),
    .res_valid (res_valid),
    .res       (back_res)
  );

  lhud_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_take && res_valid),
    .wr_data (back_res),
    .rd_en   (pop),
    .rd_data (res_q_data),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_res         = lhud_pkg::result_t'(res_q_data);
  assign kind            = out_res.kind;
  assign data_byte       = out_res.data_byte;
  assign declared_length = out_res.declared_length;
  assign byte_index      = out_res.byte_index;
  assign beyond_length   = out_res.beyond_length;
  assign out_last        = out_res.last;

  // Every error result closes its message.
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == lhud_pkg::KIND_BAD_HEADER || kind == lhud_pkg::KIND_BAD_ESCAPE))
    |-> out_last)
    else $error("error result without out_last");

  // Only data results carry a byte or a beyond-length flag.
  a_nondata_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != lhud_pkg::KIND_DATA) |-> (data_byte == '0 && !beyond_length))
    else $error("non-data result carries data fields");

  // The length report comes before any body byte, so its index is zero.
  a_length_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == lhud_pkg::KIND_LENGTH) |-> (byte_index == '0))
    else $error("length result with nonzero index");

endmodule

`default_nettype wire

### tb/sv/lhud_result_checker.sv
// Result checker for the length-header unescape decoder testbench.
// Watches the request and result queue ports, predicts each result and
// compares it; depends on lhud_pkg for the result record and the codes.
`timescale 1ns / 1ps

module lhud_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [31:0] declared_length,
  input  logic [31:0] byte_index,
  input  logic        beyond_length,
  input  logic        out_last,
  output int          failures,
  output int          pending
);

  // Decoder state as predicted from the accepted requests.
  lhud_pkg::phase_t  dec_phase;
  logic [31:0]       len_acc;
  logic [31:0]       next_index;
  lhud_pkg::result_t expected_results[$];
  int                mismatch_count = 0;

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %s mismatch, got %0h, want %0h, at %0t", field, got, want, $time);
    mismatch_count++;
    failures = mismatch_count;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic last);
    lhud_pkg::result_t r;
    logic    produce;
    logic    follower_ok;
    logic [7:0] decoded;
    r = '0;
    produce = 1'b0;
    follower_ok = 1'b1;
    decoded = lhud_pkg::BYTE_NUL;
    r.byte_index = next_index;
    case (dec_phase)
      lhud_pkg::PH_HEADER: begin
        if (ch == lhud_pkg::CH_COLON) begin
          r.kind = lhud_pkg::KIND_LENGTH;
          r.last = last;
          produce = 1'b1;
          dec_phase = lhud_pkg::PH_BODY;
        end else begin
          len_acc = len_acc * 32'd10 + {24'd0, ch} - 32'd48;
          if (last) begin
            r.kind = lhud_pkg::KIND_BAD_HEADER;
            r.last = 1'b1;
            produce = 1'b1;
          end
        end
      end
      lhud_pkg::PH_BODY: begin
        if (ch == lhud_pkg::CH_PIPE) begin
          if (last) begin
            r.kind = lhud_pkg::KIND_BAD_ESCAPE;
            r.last = 1'b1;
            produce = 1'b1;
          end else begin
            dec_phase = lhud_pkg::PH_ESCAPE;
          end
        end else begin
          r.kind = lhud_pkg::KIND_DATA;
          r.data_byte = ch;
          r.beyond_length = (next_index >= len_acc);
          r.last = last;
          produce = 1'b1;
          next_index++;
        end
      end
      lhud_pkg::PH_ESCAPE: begin
        case (ch)
          lhud_pkg::CH_Z: decoded = lhud_pkg::BYTE_NUL;
          lhud_pkg::CH_L: decoded = lhud_pkg::BYTE_LF;
          lhud_pkg::CH_F: decoded = lhud_pkg::BYTE_CR;
          lhud_pkg::CH_P: decoded = lhud_pkg::CH_PIPE;
          default: follower_ok = 1'b0;
        endcase
        produce = 1'b1;
        if (follower_ok) begin
          r.kind = lhud_pkg::KIND_DATA;
          r.data_byte = decoded;
          r.beyond_length = (next_index >= len_acc);
          r.last = last;
          next_index++;
          dec_phase = lhud_pkg::PH_BODY;
        end else begin
          r.kind = lhud_pkg::KIND_BAD_ESCAPE;
          r.last = 1'b1;
          dec_phase = lhud_pkg::PH_DROP;
        end
      end
      default: ;
    endcase
    r.declared_length = len_acc;
    if (produce) expected_results.push_back(r);
    if (last) begin
      dec_phase  = lhud_pkg::PH_HEADER;
      len_acc    = '0;
      next_index = '0;
    end
  endtask

  always @(posedge clk) begin
    lhud_pkg::result_t want;
    if (rst) begin
      dec_phase  = lhud_pkg::PH_HEADER;
      len_acc    = '0;
      next_index = '0;
      expected_results.delete();
    end else begin
      // Results leave only after passing the command queue and the result queue,
      // so the pop side never concerns the request taken at this same edge.
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, kind", {30'd0, kind}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind) report_mismatch("kind", {30'd0, kind}, {30'd0, want.kind});
          if (data_byte !== want.data_byte)
            report_mismatch("data_byte", {24'd0, data_byte}, {24'd0, want.data_byte});
          if (declared_length !== want.declared_length)
            report_mismatch("declared_length", declared_length, want.declared_length);
          if (byte_index !== want.byte_index)
            report_mismatch("byte_index", byte_index, want.byte_index);
          if (beyond_length !== want.beyond_length)
            report_mismatch("beyond_length", {31'd0, beyond_length}, {31'd0, want.beyond_length});
          if (out_last !== want.last)
            report_mismatch("out_last", {31'd0, out_last}, {31'd0, want.last});
        end
      end
      if (push && !full) decode_char(in_byte, in_last);
    end
    pending <= expected_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the length-header unescape decoder testbench.
// Drives messages into length_header_unescape_decoder_unit and gives the
// verdict; depends on lhud_pkg and on lhud_result_checker for the checks.
`timescale 1ns / 1ps

module tb_top;

  // Receiver behavior: pop every cycle, pop on a coin toss, or pop rarely so
  // that the result queue fills and backpressure reaches the request side.
  typedef enum logic [1:0] {
    DRAIN_ALWAYS,
    DRAIN_COIN,
    DRAIN_SLOW
  } drain_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = lhud_pkg::CH_ZERO;
  logic        in_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] declared_length;
  logic [31:0] byte_index;
  logic        beyond_length;
  logic        out_last;
  int          failures;
  int          pending;

  // Characters of the message being built, sent oldest first.
  logic [7:0]  msg_chars[$];
  int          burst_left = 0;
  int          random_requests = 0;

  drain_mode_t drain_mode = DRAIN_ALWAYS;
  int          drain_left = 0;

  always #6 clk = ~clk;

  length_header_unescape_decoder_unit dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .data_byte       (data_byte),
    .declared_length (declared_length),
    .byte_index      (byte_index),
    .beyond_length   (beyond_length),
    .out_last        (out_last)
  );

  lhud_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .data_byte       (data_byte),
    .declared_length (declared_length),
    .byte_index      (byte_index),
    .beyond_length   (beyond_length),
    .out_last        (out_last),
    .failures        (failures),
    .pending         (pending)
  );

  // The receiver draws a new pop pattern whenever its current stretch runs out. All
  // changes happen at the falling edge so the DUT sees a settled pop.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (drain_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 2));
        drain_left = $urandom_range(32, 256);
      end
      drain_left--;
      case (drain_mode)
        DRAIN_ALWAYS: pop <= 1'b1;
        DRAIN_COIN:   pop <= 1'($urandom_range(0, 1));
        default:      pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Sends one request. The sender works in bursts: when a burst is used up,
  // push drops for a random gap and a new burst length is drawn, now and
  // then a long one so that stretches at full rate occur too. The task is
  // entered and left at a falling edge.
  task automatic send_item(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    push    <= 1'b1;
    in_byte <= ch;
    in_last <= last;
    // The request is taken at the first rising edge that sees full low.
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Sends the built message, with in_last on its final character.
  task automatic send_message();
    int i;
    for (i = 0; i < msg_chars.size(); i++) begin
      send_item(msg_chars[i], i == msg_chars.size() - 1);
    end
  endtask

  // Appends a decimal header of n digits.
  task automatic add_digits(input int n);
    int i;
    for (i = 0; i < n; i++)
      msg_chars.push_back(lhud_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Appends a clean escaped body of n decoded characters; about one in six
  // is an escape pair with a valid follower.
  task automatic add_body(input int n);
    int i;
    logic [7:0] ch;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        msg_chars.push_back(lhud_pkg::CH_PIPE);
        case ($urandom_range(0, 3))
          0: msg_chars.push_back(lhud_pkg::CH_Z);
          1: msg_chars.push_back(lhud_pkg::CH_L);
          2: msg_chars.push_back(lhud_pkg::CH_F);
          default: msg_chars.push_back(lhud_pkg::CH_P);
        endcase
      end else begin
        do ch = 8'($urandom_range(1, 255)); while (ch == lhud_pkg::CH_PIPE);
        msg_chars.push_back(ch);
      end
    end
  endtask

  // Appends n arbitrary characters; a colon is left out when not allowed,
  // which keeps a header from ending.
  task automatic add_noise(input int n, input logic allow_colon);
    int i;
    logic [7:0] ch;
    for (i = 0; i < n; i++) begin
      do ch = 8'($urandom_range(1, 255));
      while (!allow_colon && ch == lhud_pkg::CH_COLON);
      msg_chars.push_back(ch);
    end
  endtask

  initial begin
    logic [7:0] follower;
    int         sel;
    int         n_digits;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Length two with six body characters: the lowest and
    // highest byte values, all four escape pairs, and indices that run past
    // the declared length.
    msg_chars = {lhud_pkg::CH_ZERO + 8'd2, lhud_pkg::CH_COLON, 8'h01,
                 lhud_pkg::CH_PIPE, lhud_pkg::CH_Z, lhud_pkg::CH_PIPE, lhud_pkg::CH_L,
                 lhud_pkg::CH_PIPE, lhud_pkg::CH_F, lhud_pkg::CH_PIPE, lhud_pkg::CH_P,
                 8'hFF};
    send_message();
    // A colon as the only and last character: the length result closes the
    // message with an empty body.
    msg_chars = {lhud_pkg::CH_COLON};
    send_message();
    // An escape on the last character, so the follower is missing.
    msg_chars = {lhud_pkg::CH_ZERO + 8'd1, lhud_pkg::CH_COLON, lhud_pkg::CH_PIPE};
    send_message();
    // A wrong follower, after which the rest of the message is dropped.
    msg_chars = {lhud_pkg::CH_ZERO, lhud_pkg::CH_COLON, lhud_pkg::CH_PIPE, 8'h51,
                 lhud_pkg::CH_PIPE, 8'h7F};
    send_message();
    // The message ends before any colon, with non-digit header characters.
    msg_chars = {8'hFF, 8'hFF};
    send_message();

    // Random part: mostly well-formed messages with random content, the
    // rest broken headers, broken escapes and plain noise.
    while (random_requests < 800) begin
      msg_chars.delete();
      sel = $urandom_range(0, 15);
      // Short headers keep the declared length near the body length so the
      // beyond-length flag takes both values; long ones overflow the length.
      case ($urandom_range(0, 9))
        0: n_digits = 0;
        1: n_digits = $urandom_range(10, 14);
        default: n_digits = $urandom_range(1, 2);
      endcase
      if (sel <= 9) begin
        add_digits(n_digits);
        msg_chars.push_back(lhud_pkg::CH_COLON);
        add_body($urandom_range(0, 12));
      end else if (sel == 10) begin
        add_noise($urandom_range(1, 6), 1'b0);
      end else if (sel == 11) begin
        add_noise($urandom_range(1, 6), 1'b0);
        msg_chars.push_back(lhud_pkg::CH_COLON);
        add_body($urandom_range(0, 8));
      end else if (sel == 12) begin
        add_digits(n_digits);
        msg_chars.push_back(lhud_pkg::CH_COLON);
        add_body($urandom_range(0, 6));
        do follower = 8'($urandom_range(1, 255));
        while (follower == lhud_pkg::CH_Z || follower == lhud_pkg::CH_L ||
               follower == lhud_pkg::CH_F || follower == lhud_pkg::CH_P);
        msg_chars.push_back(lhud_pkg::CH_PIPE);
        msg_chars.push_back(follower);
        add_noise($urandom_range(0, 4), 1'b1);
      end else if (sel == 13) begin
        add_digits(n_digits);
        msg_chars.push_back(lhud_pkg::CH_COLON);
        add_body($urandom_range(0, 6));
        msg_chars.push_back(lhud_pkg::CH_PIPE);
      end else begin
        add_noise($urandom_range(1, 10), 1'b1);
      end
      random_requests += msg_chars.size();
      send_message();
    end

    // Drain: wait for every predicted result, then wait on so that a stray extra
    // result would still show up.
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
sv/lhud_pkg.sv
sv/lhud_fifo.sv
sv/lhud_front.sv
sv/lhud_back.sv
sv/length_header_unescape_decoder_unit.sv
tb/sv/lhud_result_checker.sv
tb/sv/tb_top.sv
